/* hdl/dssv_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dssv_pkg
// Shared types and constants of the dual slot save validator.
// ----------------------------------------------------------------------------
package dssv_pkg;

    localparam int MAGIC_W   = 32;
    localparam int SEC_W     = 4;
    localparam int MASK_W    = 16;
    localparam int CSUM_W    = 16;
    localparam int CNT_W     = 32;

    localparam int SECTIONS_DEF = 14;

    localparam logic [MAGIC_W-1:0] MAGIC_RESET  = 32'h0801_B025;
    localparam logic [CNT_W-1:0]   COUNTER_ONES = {CNT_W{1'b1}};
    localparam logic [CNT_W-1:0]   COUNTER_ZERO = '0;

    // slot classification
    typedef enum logic [1:0] {
        CLS_EMPTY,
        CLS_COMPLETE,
        CLS_CORRUPT
    } slot_class_t;

    // status codes on the result port
    typedef enum logic [1:0] {
        STAT_NONE,
        STAT_OK,
        STAT_OK_OTHER_BAD,
        STAT_BOTH_BAD
    } status_t;

    // header update presented to one slot tracker
    typedef struct packed {
        logic              hit;
        logic              magic_ok;
        logic              sum_ok;
        logic [SEC_W-1:0]  section;
        logic [CNT_W-1:0]  counter;
    } slot_upd_t;

    // slot state including the header being absorbed
    typedef struct packed {
        logic              seen;
        logic [MASK_W-1:0] mask;
        logic [CNT_W-1:0]  counter;
    } slot_view_t;

    // classify one slot against the full section mask
    function automatic slot_class_t classify(input slot_view_t v,
                                             input logic [MASK_W-1:0] full);
        slot_class_t c;
        if (!v.seen)
            c = CLS_EMPTY;
        else if (v.mask == full)
            c = CLS_COMPLETE;
        else
            c = CLS_CORRUPT;
        return c;
    endfunction

endpackage
`default_nettype wire

/* hdl/dssv_slot.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dssv_slot
// Per-slot tracker: seen-magic flag, matching section mask and last counter.
// ----------------------------------------------------------------------------
module dssv_slot (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire dssv_pkg::slot_upd_t   upd,
    input  wire logic                  commit,
    input  wire logic                  clear,
    output dssv_pkg::slot_view_t       view
);

    logic                          seen_reg;
    logic [dssv_pkg::MASK_W-1:0]   mask_reg;
    logic [dssv_pkg::CNT_W-1:0]    counter_reg;
    logic                          take_magic;
    logic                          take_sum;
    logic [dssv_pkg::MASK_W-1:0]   sec_bit;

    // state as it stands once the current header is absorbed
    always_comb
    begin
        take_magic   = upd.hit && upd.magic_ok;
        take_sum     = take_magic && upd.sum_ok;
        sec_bit      = dssv_pkg::MASK_W'(1) << upd.section;
        view.seen    = seen_reg | take_magic;
        view.mask    = take_sum ? (mask_reg | sec_bit) : mask_reg;
        view.counter = take_sum ? upd.counter : counter_reg;
    end

    // state register, cleared after a decision
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg    <= 1'b0;
            mask_reg    <= '0;
            counter_reg <= '0;
        end
        else if (commit)
        begin
            if (clear)
            begin
                seen_reg    <= 1'b0;
                mask_reg    <= '0;
                counter_reg <= '0;
            end
            else
            begin
                seen_reg    <= view.seen;
                mask_reg    <= view.mask;
                counter_reg <= view.counter;
            end
        end
    end

endmodule
`default_nettype wire

/* hdl/dssv_decide.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dssv_decide
// Classifies both slots, picks the newer complete one and holds the result.
// ----------------------------------------------------------------------------
module dssv_decide #(
    parameter int SECTIONS = dssv_pkg::SECTIONS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire dssv_pkg::slot_view_t         view0,
    input  wire dssv_pkg::slot_view_t         view1,
    input  wire logic                         load,
    input  wire logic                         out_ready,
    output logic                              out_valid,
    output logic [1:0]                        status,
    output logic [dssv_pkg::CNT_W-1:0]        chosen_counter,
    output logic                              reset_position,
    output logic                              free
);

    localparam logic [dssv_pkg::MASK_W:0] FULL_WIDE =
        ((dssv_pkg::MASK_W+1)'(1) << SECTIONS) - (dssv_pkg::MASK_W+1)'(1);
    localparam logic [dssv_pkg::MASK_W-1:0] FULL_MASK = FULL_WIDE[dssv_pkg::MASK_W-1:0];

    dssv_pkg::slot_class_t        cls0;
    dssv_pkg::slot_class_t        cls1;
    dssv_pkg::status_t            status_next;
    logic [dssv_pkg::CNT_W-1:0]   chosen_next;
    logic                         rpos_next;
    logic                         wrap;

    logic                         out_valid_reg;
    logic [1:0]                   status_reg;
    logic [dssv_pkg::CNT_W-1:0]   chosen_reg;
    logic                         rpos_reg;

    // slot selection
    always_comb
    begin
        cls0 = dssv_pkg::classify(view0, FULL_MASK);
        cls1 = dssv_pkg::classify(view1, FULL_MASK);
        wrap = ((view0.counter == dssv_pkg::COUNTER_ONES) &&
                (view1.counter == dssv_pkg::COUNTER_ZERO)) ||
               ((view0.counter == dssv_pkg::COUNTER_ZERO) &&
                (view1.counter == dssv_pkg::COUNTER_ONES));
        rpos_next   = 1'b0;
        chosen_next = '0;
        status_next = dssv_pkg::STAT_OK;
        if ((cls0 == dssv_pkg::CLS_COMPLETE) && (cls1 == dssv_pkg::CLS_COMPLETE))
        begin
            // counter wrap: the zero side is newer
            if (wrap)
                chosen_next = dssv_pkg::COUNTER_ZERO;
            else if (view0.counter < view1.counter)
                chosen_next = view1.counter;
            else
                chosen_next = view0.counter;
        end
        else if (cls0 == dssv_pkg::CLS_COMPLETE)
        begin
            chosen_next = view0.counter;
            status_next = (cls1 == dssv_pkg::CLS_CORRUPT) ?
                          dssv_pkg::STAT_OK_OTHER_BAD : dssv_pkg::STAT_OK;
        end
        else if (cls1 == dssv_pkg::CLS_COMPLETE)
        begin
            chosen_next = view1.counter;
            status_next = (cls0 == dssv_pkg::CLS_CORRUPT) ?
                          dssv_pkg::STAT_OK_OTHER_BAD : dssv_pkg::STAT_OK;
        end
        else
        begin
            rpos_next   = 1'b1;
            status_next = ((cls0 == dssv_pkg::CLS_EMPTY) && (cls1 == dssv_pkg::CLS_EMPTY)) ?
                          dssv_pkg::STAT_NONE : dssv_pkg::STAT_BOTH_BAD;
        end
    end

    assign free = !out_valid_reg || out_ready;

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg <= status_next;
            chosen_reg <= chosen_next;
            rpos_reg   <= rpos_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign chosen_counter = chosen_reg;
    assign reset_position = rpos_reg;

    // no valid slot means rewind and zero counter
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (rpos_reg == ((status_reg == dssv_pkg::STAT_NONE) ||
                                        (status_reg == dssv_pkg::STAT_BOTH_BAD))))
        else $error("reset_position disagrees with status");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && rpos_reg |-> (chosen_reg == dssv_pkg::COUNTER_ZERO))
        else $error("counter reported with no valid slot");

endmodule
`default_nettype wire

/* hdl/dual_slot_save_validator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dual_slot_save_validator
// Checks sector headers of a two-slot save area and picks the slot to load.
// ----------------------------------------------------------------------------
// One header is taken per cycle. A header is registered on transfer together
// with its magic and checksum compares, and is absorbed into its slot's state
// as it leaves the input stage; a header marked last also runs the slot
// decision and writes the result register, so its result is presented once
// that header leaves the input stage. Throughput is one header per cycle;
// only a last header waits, while the result register still holds an untaken
// result. magic_word may be written only while no header is in flight.
module dual_slot_save_validator #(
    parameter int SECTIONS = dssv_pkg::SECTIONS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [dssv_pkg::MAGIC_W-1:0]   cfg_wdata,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           slot,
    input  wire logic [dssv_pkg::MAGIC_W-1:0]   header_magic,
    input  wire logic [dssv_pkg::SEC_W-1:0]     section_id,
    input  wire logic [dssv_pkg::CSUM_W-1:0]    stored_checksum,
    input  wire logic [dssv_pkg::CSUM_W-1:0]    computed_checksum,
    input  wire logic [dssv_pkg::CNT_W-1:0]     header_counter,
    input  wire logic                           last,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [1:0]                          status,
    output logic [dssv_pkg::CNT_W-1:0]          chosen_counter,
    output logic                                reset_position
);

    logic [dssv_pkg::MAGIC_W-1:0]   magic_reg;
    logic                           stg_valid_reg;
    logic                           stg_slot_reg;
    logic                           stg_magic_ok_reg;
    logic                           stg_sum_ok_reg;
    logic [dssv_pkg::SEC_W-1:0]     stg_section_reg;
    logic [dssv_pkg::CNT_W-1:0]     stg_counter_reg;
    logic                           stg_last_reg;

    logic                           in_xfer;
    logic                           advance;
    logic                           result_free;
    dssv_pkg::slot_upd_t            upd0;
    dssv_pkg::slot_upd_t            upd1;
    dssv_pkg::slot_view_t           view0;
    dssv_pkg::slot_view_t           view1;

    // magic word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            magic_reg <= dssv_pkg::MAGIC_RESET;
        else if (cfg_we)
            magic_reg <= cfg_wdata;
    end

    // handshake: a last header needs a free result register
    assign advance  = stg_valid_reg && (!stg_last_reg || result_free);
    assign in_ready = !stg_valid_reg || advance;
    assign in_xfer  = in_valid && in_ready;

    // input stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stg_valid_reg <= 1'b0;
        else if (in_xfer)
            stg_valid_reg <= 1'b1;
        else if (advance)
            stg_valid_reg <= 1'b0;
    end

    // input stage payload with compares done at capture
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            stg_slot_reg     <= slot;
            stg_magic_ok_reg <= (header_magic == magic_reg);
            stg_sum_ok_reg   <= (stored_checksum == computed_checksum);
            stg_section_reg  <= section_id;
            stg_counter_reg  <= header_counter;
            stg_last_reg     <= last;
        end
    end

    // route the header to its slot
    always_comb
    begin
        upd0.hit      = stg_valid_reg && !stg_slot_reg;
        upd0.magic_ok = stg_magic_ok_reg;
        upd0.sum_ok   = stg_sum_ok_reg;
        upd0.section  = stg_section_reg;
        upd0.counter  = stg_counter_reg;
        upd1          = upd0;
        upd1.hit      = stg_valid_reg && stg_slot_reg;
    end

    dssv_slot u_slot0 (
        .clk    (clk),
        .rst_n  (rst_n),
        .upd    (upd0),
        .commit (advance),
        .clear  (stg_last_reg),
        .view   (view0)
    );

    dssv_slot u_slot1 (
        .clk    (clk),
        .rst_n  (rst_n),
        .upd    (upd1),
        .commit (advance),
        .clear  (stg_last_reg),
        .view   (view1)
    );

    dssv_decide #(
        .SECTIONS (SECTIONS)
    ) u_decide (
        .clk            (clk),
        .rst_n          (rst_n),
        .view0          (view0),
        .view1          (view1),
        .load           (advance && stg_last_reg),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .status         (status),
        .chosen_counter (chosen_counter),
        .reset_position (reset_position),
        .free           (result_free)
    );

    // input stalls only behind a last header facing a full result register
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (stg_valid_reg && stg_last_reg && out_valid && !out_ready))
        else $error("input stalled without a blocked result");

    // a decided last header always yields a result
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && stg_last_reg |=> out_valid)
        else $error("last header produced no result");

    // a decision leaves both slots cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && stg_last_reg |=> (stg_valid_reg ||
            (!view0.seen && !view1.seen && (view0.mask == '0) && (view1.mask == '0))))
        else $error("slot state not cleared after decision");

endmodule
`default_nettype wire

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dual slot save validator.
// ----------------------------------------------------------------------------
// A short stimulus table covers reset state, field extremes and the corner
// cases of the slot decision. Random save-area scans follow: both slots built
// from complete, corrupt or empty sector sets, interleaved, with noise
// headers, under several magic word settings. Each scan ends on a last
// header. A local slot tracker model predicts each decision the table leaves
// open, and results are checked in order. Both handshakes idle at random, and
// the result side holds off once long enough to back up the header input.
// ----------------------------------------------------------------------------
module tb_top;

    import dssv_pkg::*;

    localparam int                SCAN_ITEMS   = 336;
    localparam int                SETTLE       = 4;
    localparam int                HOLD_CYCLES  = 300;
    localparam logic [MASK_W-1:0] ALL_SECTIONS = MASK_W'((1 << SECTIONS_DEF) - 1);

    typedef struct packed {
        logic               slot;
        logic [MAGIC_W-1:0] magic;
        logic [SEC_W-1:0]   section;
        logic [CSUM_W-1:0]  stored;
        logic [CSUM_W-1:0]  computed;
        logic [CNT_W-1:0]   counter;
        logic               last;
    } sector_hdr_t;

    typedef struct packed {
        status_t            status;
        logic [CNT_W-1:0]   counter;
        logic               reset_pos;
    } verdict_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [MAGIC_W-1:0] cfg_wdata;
    logic in_valid;
    logic in_ready;
    logic slot;
    logic [MAGIC_W-1:0] header_magic;
    logic [SEC_W-1:0] section_id;
    logic [CSUM_W-1:0] stored_checksum;
    logic [CSUM_W-1:0] computed_checksum;
    logic [CNT_W-1:0] header_counter;
    logic last;
    logic out_valid;
    logic out_ready;
    logic [1:0] status;
    logic [CNT_W-1:0] chosen_counter;
    logic reset_position;

    // model of the slot trackers
    logic               seen_q [2];
    logic [MASK_W-1:0]  mask_q [2];
    logic [CNT_W-1:0]   cnt_q  [2];
    logic [MAGIC_W-1:0] magic_q;

    verdict_t    pending_verdicts [$];
    sector_hdr_t table_hdrs [$];
    bit          table_fixed [$];
    verdict_t    table_verdicts [$];
    sector_hdr_t slot_work [$];

    int  fail_count   = 0;
    int  hdrs_sent    = 0;
    int  results_seen = 0;
    int  cycle_no     = 0;
    bit  calm;

    dual_slot_save_validator dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_wdata         (cfg_wdata),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .slot              (slot),
        .header_magic      (header_magic),
        .section_id        (section_id),
        .stored_checksum   (stored_checksum),
        .computed_checksum (computed_checksum),
        .header_counter    (header_counter),
        .last              (last),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .status            (status),
        .chosen_counter    (chosen_counter),
        .reset_position    (reset_position)
    );

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // cycle count and the stretch without idling
    always @(posedge clk)
    begin
        cycle_no <= cycle_no + 1;
        calm     <= (cycle_no >= 600) && (cycle_no < 1100);
    end

    function automatic void clear_slots();
        for (int s = 0; s < 2; s++)
        begin
            seen_q[s] = 1'b0;
            mask_q[s] = '0;
            cnt_q[s]  = '0;
        end
    endfunction

    function automatic slot_class_t grade_slot(input int s);
        if (!seen_q[s])
            return CLS_EMPTY;
        return (mask_q[s] == ALL_SECTIONS) ? CLS_COMPLETE : CLS_CORRUPT;
    endfunction

    // absorb one header; on a last header produce the slot decision
    function automatic bit absorb_header(input sector_hdr_t h, output verdict_t v);
        slot_class_t      c0;
        slot_class_t      c1;
        logic [CNT_W-1:0] a;
        logic [CNT_W-1:0] b;
        v = '0;
        if (h.magic == magic_q)
        begin
            seen_q[h.slot] = 1'b1;
            if (h.stored == h.computed)
            begin
                mask_q[h.slot] = mask_q[h.slot] | (MASK_W'(1) << h.section);
                cnt_q[h.slot]  = h.counter;
            end
        end
        if (!h.last)
            return 1'b0;
        c0 = grade_slot(0);
        c1 = grade_slot(1);
        a  = cnt_q[0];
        b  = cnt_q[1];
        v.reset_pos = 1'b0;
        if (c0 == CLS_COMPLETE && c1 == CLS_COMPLETE)
        begin
            // all-ones against zero counts as a wrap, zero is newer
            if ((a == COUNTER_ONES && b == COUNTER_ZERO) ||
                (a == COUNTER_ZERO && b == COUNTER_ONES))
                v.counter = COUNTER_ZERO;
            else
                v.counter = (a < b) ? b : a;
            v.status = STAT_OK;
        end
        else if (c0 == CLS_COMPLETE)
        begin
            v.counter = a;
            v.status  = (c1 == CLS_CORRUPT) ? STAT_OK_OTHER_BAD : STAT_OK;
        end
        else if (c1 == CLS_COMPLETE)
        begin
            v.counter = b;
            v.status  = (c0 == CLS_CORRUPT) ? STAT_OK_OTHER_BAD : STAT_OK;
        end
        else
        begin
            v.counter   = COUNTER_ZERO;
            v.reset_pos = 1'b1;
            v.status    = (c0 == CLS_EMPTY && c1 == CLS_EMPTY) ? STAT_NONE : STAT_BOTH_BAD;
        end
        clear_slots();
        return 1'b1;
    endfunction

    function automatic sector_hdr_t make_hdr(input bit s, input logic [MAGIC_W-1:0] m,
                                             input int sec, input logic [CSUM_W-1:0] st,
                                             input logic [CSUM_W-1:0] cp,
                                             input logic [CNT_W-1:0] cnt, input bit lst);
        sector_hdr_t h;
        h.slot     = s;
        h.magic    = m;
        h.section  = SEC_W'(sec);
        h.stored   = st;
        h.computed = cp;
        h.counter  = cnt;
        h.last     = lst;
        return h;
    endfunction

    // header with a wrong magic word, sometimes one bit off
    function automatic sector_hdr_t noise_hdr(input bit s);
        logic [MAGIC_W-1:0] m;
        m = ($urandom_range(0, 1) == 0) ? magic_q ^ (MAGIC_W'(1) << $urandom_range(0, 31))
                                        : MAGIC_W'($urandom);
        if (m == magic_q)
            m = ~m;
        return make_hdr(s, m, $urandom_range(0, 15), CSUM_W'($urandom), CSUM_W'($urandom),
                        CNT_W'($urandom), 1'b0);
    endfunction

    // header with the right magic but a checksum mismatch
    function automatic sector_hdr_t bad_sum_hdr(input bit s, input int sec);
        logic [CSUM_W-1:0] st;
        st = CSUM_W'($urandom);
        return make_hdr(s, magic_q, sec, st, st ^ CSUM_W'($urandom_range(1, 65535)),
                        CNT_W'($urandom), 1'b0);
    endfunction

    function automatic sector_hdr_t good_hdr(input bit s, input int sec,
                                             input logic [CNT_W-1:0] cnt);
        logic [CSUM_W-1:0] sum;
        sum = CSUM_W'($urandom);
        return make_hdr(s, magic_q, sec, sum, sum, cnt, 1'b0);
    endfunction

    function automatic void add_row(input sector_hdr_t h, input bit fixed,
                                    input status_t st, input logic [CNT_W-1:0] cnt,
                                    input logic rp);
        verdict_t v;
        v.status    = st;
        v.counter   = cnt;
        v.reset_pos = rp;
        table_hdrs.push_back(h);
        table_fixed.push_back(fixed);
        table_verdicts.push_back(v);
    endfunction

    // headers of one slot for one scan
    function automatic void fill_slot(input bit s, input slot_class_t mode,
                                      input logic [CNT_W-1:0] cnt);
        int order [SECTIONS_DEF];
        int drop;
        int j;
        int tmp;
        slot_work.delete();
        if (mode == CLS_EMPTY)
        begin
            repeat ($urandom_range(0, 3))
                slot_work.push_back(noise_hdr(s));
            return;
        end
        for (int i = 0; i < SECTIONS_DEF; i++)
            order[i] = i;
        for (int i = SECTIONS_DEF - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        drop = -1;
        if (mode == CLS_CORRUPT && $urandom_range(0, 1) == 1)
            drop = $urandom_range(0, SECTIONS_DEF - 1);
        for (int i = 0; i < SECTIONS_DEF; i++)
        begin
            if (order[i] == drop)
            begin
                if ($urandom_range(0, 1) == 1)
                    slot_work.push_back(bad_sum_hdr(s, order[i]));
            end
            else
            begin
                if ($urandom_range(0, 99) < 20)
                    slot_work.push_back(bad_sum_hdr(s, order[i]));
                if ($urandom_range(0, 99) < 15)
                    slot_work.push_back(noise_hdr(s));
                slot_work.push_back(good_hdr(s, order[i], cnt));
            end
        end
        // section beyond range spoils an otherwise full mask
        if (mode == CLS_CORRUPT && drop < 0)
            slot_work.push_back(good_hdr(s, $urandom_range(SECTIONS_DEF, 15), cnt));
    endfunction

    function automatic slot_class_t pick_mode();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
            return CLS_COMPLETE;
        return (r < 8) ? CLS_CORRUPT : CLS_EMPTY;
    endfunction

    function automatic logic [CNT_W-1:0] pick_counter(input logic [CNT_W-1:0] other);
        case ($urandom_range(0, 7))
            0:       return COUNTER_ZERO;
            1:       return COUNTER_ONES;
            2:       return other;
            3:       return other + 1'b1;
            4:       return other - 1'b1;
            5:       return CNT_W'($urandom_range(0, 15));
            default: return CNT_W'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [CNT_W-1:0] want,
                                   input logic [CNT_W-1:0] got);
        $display("mismatch at cycle %0d, %s: expected %0h, got %0h", cycle_no, what, want, got);
        fail_count++;
    endtask

    // offer one header and wait for its transfer
    task automatic offer_header(input sector_hdr_t h, input bit fixed, input verdict_t fixed_v);
        verdict_t v;
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < 16)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid          = 1'b1;
        slot              = h.slot;
        header_magic      = h.magic;
        section_id        = h.section;
        stored_checksum   = h.stored;
        computed_checksum = h.computed;
        header_counter    = h.counter;
        last              = h.last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        hdrs_sent++;
        if (absorb_header(h, v))
            pending_verdicts.push_back(fixed ? fixed_v : v);
    endtask

    // one scan of the save area, ending on a last header
    task automatic run_scan();
        sector_hdr_t      qa [$];
        sector_hdr_t      qb [$];
        sector_hdr_t      merged [$];
        slot_class_t      mode_a;
        slot_class_t      mode_b;
        logic [CNT_W-1:0] ca;
        logic [CNT_W-1:0] cb;
        verdict_t         none;
        int               pick;
        none = '0;
        if ($urandom_range(0, 99) < 12)
        begin
            // short scan of one or two arbitrary headers
            repeat ($urandom_range(1, 2))
                merged.push_back(make_hdr(1'($urandom_range(0, 1)),
                                          ($urandom_range(0, 1) == 1) ? magic_q
                                                                      : MAGIC_W'($urandom),
                                          $urandom_range(0, 15), CSUM_W'($urandom_range(0, 3)),
                                          CSUM_W'($urandom_range(0, 3)), CNT_W'($urandom),
                                          1'b0));
        end
        else
        begin
            mode_a = pick_mode();
            mode_b = pick_mode();
            if ($urandom_range(0, 9) < 3)
            begin
                // counters on both sides of the wrap
                ca = ($urandom_range(0, 1) == 1) ? COUNTER_ONES : COUNTER_ZERO;
                cb = ~ca;
            end
            else
            begin
                ca = pick_counter(CNT_W'($urandom));
                cb = pick_counter(ca);
            end
            fill_slot(1'b0, mode_a, ca);
            qa = slot_work;
            fill_slot(1'b1, mode_b, cb);
            qb = slot_work;
            while (qa.size() != 0 || qb.size() != 0)
            begin
                if (qb.size() == 0)
                    pick = 0;
                else if (qa.size() == 0)
                    pick = 1;
                else
                    pick = $urandom_range(0, 1);
                merged.push_back((pick == 1) ? qb.pop_front() : qa.pop_front());
            end
            if (merged.size() == 0)
                merged.push_back(noise_hdr(1'($urandom_range(0, 1))));
        end
        merged[merged.size() - 1].last = 1'b1;
        foreach (merged[i])
            offer_header(merged[i], 1'b0, none);
    endtask

    task automatic drain_verdicts();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    // register write once the block is idle
    task automatic write_magic(input logic [MAGIC_W-1:0] value);
        drain_verdicts();
        repeat (SETTLE)
            @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we    = 1'b0;
        magic_q   = value;
    endtask

    // result side: ready with random idling and one long hold-off
    initial
    begin
        int  hold_left;
        bit  hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && results_seen >= 6)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_ready = 1'b0;
                hold_left--;
            end
            else
                out_ready = calm || ($urandom_range(0, 99) >= 16);
        end
    end

    // result check on each transfer
    always @(posedge clk)
    begin
        verdict_t want;
        if (out_valid && out_ready)
        begin
            results_seen++;
            if (pending_verdicts.size() == 0)
                report_mismatch("result with nothing pending", '0, chosen_counter);
            else
            begin
                want = pending_verdicts.pop_front();
                if (want.status !== status)
                    report_mismatch("status", CNT_W'(want.status), CNT_W'(status));
                if (want.counter !== chosen_counter)
                    report_mismatch("chosen_counter", want.counter, chosen_counter);
                if (want.reset_pos !== reset_position)
                    report_mismatch("reset_position", CNT_W'(want.reset_pos),
                                    CNT_W'(reset_position));
            end
        end
    end

    // stimulus
    initial
    begin
        logic [MAGIC_W-1:0] phase_magic [5];
        int                 phase_end;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = '0;
        in_valid          = 1'b0;
        slot              = 1'b0;
        header_magic      = '0;
        section_id        = '0;
        stored_checksum   = '0;
        computed_checksum = '0;
        header_counter    = '0;
        last              = 1'b0;
        magic_q           = MAGIC_RESET;
        clear_slots();

        // table: empty, corrupt, one complete slot at the extremes, stray sections
        add_row(make_hdr(0, ~MAGIC_RESET, 0, 16'h0000, 16'h0000, COUNTER_ZERO, 1),
                1'b1, STAT_NONE, COUNTER_ZERO, 1'b1);
        add_row(make_hdr(1, MAGIC_RESET, 15, 16'hFFFF, 16'h0000, COUNTER_ONES, 1),
                1'b1, STAT_BOTH_BAD, COUNTER_ZERO, 1'b1);
        for (int i = 0; i < SECTIONS_DEF - 1; i++)
            add_row(make_hdr(0, MAGIC_RESET, i, (i % 2) ? 16'hFFFF : 16'h0000,
                             (i % 2) ? 16'hFFFF : 16'h0000, CNT_W'(i), 0),
                    1'b0, STAT_NONE, COUNTER_ZERO, 1'b0);
        add_row(make_hdr(0, MAGIC_RESET, SECTIONS_DEF - 1, 16'hFFFF, 16'hFFFF, COUNTER_ONES, 1),
                1'b1, STAT_OK, COUNTER_ONES, 1'b0);
        add_row(make_hdr(1, MAGIC_RESET, 15, 16'h0005, 16'h0005, CNT_W'(7), 1),
                1'b1, STAT_BOTH_BAD, COUNTER_ZERO, 1'b1);
        add_row(make_hdr(0, MAGIC_RESET, 14, 16'h0000, 16'h0000, COUNTER_ONES, 0),
                1'b0, STAT_NONE, COUNTER_ZERO, 1'b0);
        add_row(make_hdr(1, MAGIC_RESET, 0, 16'h0001, 16'h0001, CNT_W'(9), 1),
                1'b0, STAT_NONE, COUNTER_ZERO, 1'b0);
        add_row(make_hdr(0, MAGIC_RESET, 0, 16'h0000, 16'h0000, COUNTER_ZERO, 1),
                1'b0, STAT_NONE, COUNTER_ZERO, 1'b0);

        phase_magic[0] = MAGIC_RESET;
        phase_magic[1] = '0;
        phase_magic[2] = '1;
        phase_magic[3] = MAGIC_W'($urandom);
        phase_magic[4] = MAGIC_RESET;

        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (table_hdrs[i])
            offer_header(table_hdrs[i], table_fixed[i], table_verdicts[i]);

        // random scans under each magic word setting
        for (int p = 0; p < 5; p++)
        begin
            if (p > 0)
                write_magic(phase_magic[p]);
            phase_end = hdrs_sent + SCAN_ITEMS;
            while (hdrs_sent < phase_end)
                run_scan();
        end

        drain_verdicts();
        repeat (8)
            @(posedge clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // watchdog
    initial
    begin
        #1000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
